@@ design/fblm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblm_pkg
// Shared sizes, codes, types and build-time tables of the band level meter.
// ----------------------------------------------------------------------------
package fblm_pkg;

    localparam int FFT_POINTS  = 512;
    localparam int NUM_BANDS   = 24;
    localparam int LOG2_POINTS = $clog2(FFT_POINTS);
    localparam int HALF_POINTS = FFT_POINTS / 2;
    localparam int ADDR_W      = LOG2_POINTS;
    localparam int TW_W        = LOG2_POINTS - 1;
    localparam int FC_W        = ADDR_W + 1;
    localparam int STAGE_W     = $clog2(LOG2_POINTS);
    localparam int BAND_W      = $clog2(NUM_BANDS);
    localparam int WORD_W      = 24;
    localparam int CPLX_W      = 2 * WORD_W;
    localparam int SQ_IN_W     = 2 * WORD_W;
    localparam int SQ_OUT_W    = WORD_W;
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int IN_DATA_W   = 2 * SAMPLE_W;
    localparam int OUT_DATA_W  = ((BAND_W + LEVEL_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WIN_DEN     = FFT_POINTS - 1;

    localparam longint ONE_Q30 = 64'd1073741824;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    localparam logic                  STEREO_MIX_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] FALL_STEP_RST  = 16'd1311;
    localparam logic [CFG_DATA_W-1:0] LEVEL_GAIN_RST = 16'd9011;
    localparam logic [LEVEL_W:0]      LEVEL_ONE      = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEREO_MIX = 2'd0,
        CFG_FALL_STEP  = 2'd1,
        CFG_LEVEL_GAIN = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_LMUL, S_LWR, S_PAD,
        S_FRD, S_FM0, S_FM1, S_FM2, S_FM3, S_FM4, S_FWA, S_FWB,
        S_BINIT, S_PCHK, S_PRD, S_PRE, S_PIM, S_PCMP,
        S_SQS1, S_SQW1, S_SQS2, S_SQW2, S_LVL, S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic                done;
        logic [SQ_OUT_W-1:0] root;
    } t_sqrt_rsp;

    typedef logic signed [15:0] t_tw_tab  [HALF_POINTS];
    typedef logic        [15:0] t_win_tab [FFT_POINTS];
    typedef logic [ADDR_W-1:0]  t_bin_tab [NUM_BANDS];

    function automatic logic signed [WORD_W-1:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -48'sd8388608)
            return 24'sh800000;
        else
            return v[WORD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int k = 0; k < ADDR_W; k++)
            r[k] = v[ADDR_W-1-k];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        else if (v < -32768)
            return 16'sh8000;
        else
            return 16'(v);
    endfunction

    // Cosine or sine of a turn fraction (Q32 of a full turn) in Q30, by a
    // Taylor series on the first quadrant.
    function automatic longint trig_q30(input longint unsigned frac, input bit want_sin);
        longint unsigned x;
        longint unsigned term;
        longint cs;
        longint sn;
        longint c;
        longint s;
        int unsigned quad;
        quad = int'((frac >> 30) & 64'd3);
        x    = ((frac & 64'h3FFF_FFFF) * PI_HALF_Q30) >> 30;
        term = ONE_Q30;
        cs   = ONE_Q30;
        sn   = 0;
        for (int n = 1; n <= 16; n++) begin
            term = (term * x) >> 30;
            case (n)
                1:  term = term / 1;
                2:  term = term / 2;
                3:  term = term / 3;
                4:  term = term / 4;
                5:  term = term / 5;
                6:  term = term / 6;
                7:  term = term / 7;
                8:  term = term / 8;
                9:  term = term / 9;
                10: term = term / 10;
                11: term = term / 11;
                12: term = term / 12;
                13: term = term / 13;
                14: term = term / 14;
                15: term = term / 15;
                default: term = term / 16;
            endcase
            case (n % 4)
                1: sn = sn + longint'(term);
                2: cs = cs - longint'(term);
                3: sn = sn - longint'(term);
                default: cs = cs + longint'(term);
            endcase
        end
        case (quad)
            0: begin c = cs;  s = sn;  end
            1: begin c = -sn; s = cs;  end
            2: begin c = -cs; s = -sn; end
            default: begin c = sn; s = -cs; end
        endcase
        return want_sin ? s : c;
    endfunction

    function automatic t_tw_tab build_tw(input bit want_sin);
        t_tw_tab t;
        longint unsigned frac;
        for (int i = 0; i < HALF_POINTS; i++) begin
            frac = (longint'(i) << 32) / FFT_POINTS;
            t[i] = sat16((trig_q30(frac, want_sin) + 64'sd16384) >>> 15);
        end
        return t;
    endfunction

    function automatic t_win_tab build_win();
        t_win_tab t;
        longint unsigned frac;
        longint v;
        for (int i = 0; i < FFT_POINTS; i++) begin
            frac = (longint'(i % WIN_DEN) << 32) / WIN_DEN;
            v    = (ONE_Q30 - trig_q30(frac, 1'b0) + 64'sd32768) >>> 16;
            t[i] = 16'(v);
        end
        return t;
    endfunction

    // True when x to the power NUM_BANDS is at most 2^p.
    function automatic bit pow_within(input longint unsigned x, input int p);
        longint unsigned mant;
        longint unsigned lim;
        int ex;
        bit sticky;
        mant   = 1;
        ex     = 0;
        sticky = 1'b0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            mant = mant * x;
            while (mant >= (64'd1 << 48)) begin
                sticky = sticky | mant[0];
                mant   = mant >> 1;
                ex++;
            end
        end
        if (ex > p)
            return 1'b0;
        if (p - ex >= 63)
            return 1'b1;
        lim = 64'd1 << (p - ex);
        return (mant < lim) || (mant == lim && !sticky);
    endfunction

    function automatic longint unsigned band_edge(input int b);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        int p;
        lo = 1;
        hi = HALF_POINTS;
        p  = (LOG2_POINTS - 1) * b;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (pow_within(mid, p))
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_bin_tab build_bins(input bit want_hi);
        t_bin_tab t;
        longint unsigned lo;
        longint unsigned hi;
        for (int b = 0; b < NUM_BANDS; b++) begin
            lo = 1 + band_edge(b);
            hi = 1 + band_edge(b + 1);
            if (hi <= lo)
                hi = lo + 1;
            if (hi > HALF_POINTS)
                hi = HALF_POINTS;
            t[b] = want_hi ? ADDR_W'(hi) : ADDR_W'(lo);
        end
        return t;
    endfunction

    localparam t_tw_tab  COS_TAB = build_tw(1'b0);
    localparam t_tw_tab  SIN_TAB = build_tw(1'b1);
    localparam t_win_tab WIN_TAB = build_win();
    localparam t_bin_tab BAND_LO = build_bins(1'b0);
    localparam t_bin_tab BAND_HI = build_bins(1'b1);

endpackage

@@ design/fblm_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblm_isqrt
// Integer square root, rounded down, one result bit per cycle.
// ----------------------------------------------------------------------------
module fblm_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fblm_pkg::t_sqrt_req i_req,
    output fblm_pkg::t_sqrt_rsp o_rsp
);

    localparam int CNT_W = $clog2(fblm_pkg::SQ_OUT_W);
    localparam int REM_W = fblm_pkg::SQ_OUT_W + 3;

    logic [fblm_pkg::SQ_IN_W-1:0]  r_rad;
    logic [REM_W-1:0]              r_rem;
    logic [fblm_pkg::SQ_OUT_W-1:0] r_root;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [REM_W-1:0] cat;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign cat   = {r_rem[REM_W-3:0], r_rad[fblm_pkg::SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = (cat >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fblm_pkg::SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (fits) begin
                r_rem  <= cat - trial;
                r_root <= {r_root[fblm_pkg::SQ_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= cat;
                r_root <= {r_root[fblm_pkg::SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

@@ design/fft_band_level_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_band_level_meter
// 512-point FFT spectrum meter giving 24 smoothed band levels per chunk.
// ----------------------------------------------------------------------------
// Input beats carry one PCM frame: sample_a in tdata[15:0], sample_b in
// tdata[31:16], and tlast marks the last frame of a chunk. For each frame the
// window product goes through the shared multiplier and the result is written
// to the sample RAM at its bit-reversed address.
// After a chunk's last frame the block pads the remaining RAM entries (one
// per cycle), runs 9 FFT passes of 256 butterflies, each butterfly writing
// its two results through the single RAM write port, then for each band
// scans its bins and runs two square roots of 24 result bits each. The 24
// band beats leave in band order, tlast on the last one. No input is taken
// until the last band has been handed to the output register.
// The output register holds a beat while the receiver stalls; band work
// waits for it, and the next chunk's frames are accepted while the final
// beat is still waiting. Reset loads the register defaults, zeroes the bars
// and the frame count; the sample RAM needs no clearing.
// ----------------------------------------------------------------------------
module fft_band_level_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [fblm_pkg::IN_DATA_W-1:0]      i_s_tdata,  // sample_a, sample_b
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [fblm_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // band_index, bar_level, pad
    output logic                                o_m_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [fblm_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [fblm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WW = fblm_pkg::WORD_W;

    fblm_pkg::t_state r_state, n_state;

    // Configuration.
    logic                            r_stereo_mix;
    logic [fblm_pkg::CFG_DATA_W-1:0] r_fall_step;
    logic [fblm_pkg::CFG_DATA_W-1:0] r_level_gain;

    // Sample RAM: imag in the upper half, real in the lower half.
    logic [fblm_pkg::CPLX_W-1:0] r_mem [fblm_pkg::FFT_POINTS];
    logic [fblm_pkg::CPLX_W-1:0] r_rd_a;
    logic [fblm_pkg::CPLX_W-1:0] r_rd_b;
    logic                        mem_we;
    logic [fblm_pkg::ADDR_W-1:0] mem_wa;
    logic [fblm_pkg::CPLX_W-1:0] mem_wd;
    logic [fblm_pkg::ADDR_W-1:0] rd_addr_a;
    logic [fblm_pkg::ADDR_W-1:0] rd_addr_b;

    logic [15:0] r_win;

    logic [fblm_pkg::FC_W-1:0]    r_fc;
    logic signed [16:0]           r_x;
    logic                         r_last;
    logic [fblm_pkg::STAGE_W-1:0] r_stage;
    logic [fblm_pkg::TW_W-1:0]    r_bfly;
    logic signed [WW-1:0]         r_wr;
    logic signed [WW-1:0]         r_wi;
    logic signed [47:0]           r_prod;
    logic signed [48:0]           r_acc;
    logic signed [26:0]           r_tr;
    logic signed [26:0]           r_ti;
    logic [fblm_pkg::CPLX_W-1:0]  r_new_b;
    logic [fblm_pkg::BAND_W-1:0]  r_band;
    logic [fblm_pkg::ADDR_W-1:0]  r_bin;
    logic [fblm_pkg::SQ_IN_W-1:0] r_peak;
    logic [WW-1:0]                r_mag;
    logic [15:0]                  r_root;
    logic [fblm_pkg::LEVEL_W-1:0] r_bar [fblm_pkg::NUM_BANDS];

    logic                         r_out_valid;
    logic [fblm_pkg::BAND_W-1:0]  r_out_band;
    logic [fblm_pkg::LEVEL_W-1:0] r_out_level;
    logic                         r_out_last;

    fblm_pkg::t_sqrt_req sq_req;
    fblm_pkg::t_sqrt_rsp sq_rsp;

    logic in_take;
    logic out_free;

    // ------------------------------------------------------------------
    // Butterfly addressing.
    logic [fblm_pkg::ADDR_W-1:0] lo_mask;
    logic [fblm_pkg::ADDR_W-1:0] bf_ext;
    logic [fblm_pkg::ADDR_W-1:0] addr_a;
    logic [fblm_pkg::ADDR_W-1:0] addr_b;
    logic [fblm_pkg::TW_W-1:0]   tw_k;
    logic [fblm_pkg::TW_W-1:0]   tw_idx;
    logic [fblm_pkg::STAGE_W-1:0] tw_sh;

    assign lo_mask = (fblm_pkg::ADDR_W'(1) << r_stage) - 1'b1;
    assign bf_ext  = fblm_pkg::ADDR_W'(r_bfly);
    assign addr_a  = ((bf_ext & ~lo_mask) << 1) | (bf_ext & lo_mask);
    assign addr_b  = addr_a | (fblm_pkg::ADDR_W'(1) << r_stage);
    assign tw_k    = r_bfly & lo_mask[fblm_pkg::TW_W-1:0];
    assign tw_sh   = fblm_pkg::STAGE_W'(fblm_pkg::LOG2_POINTS - 1) - r_stage;
    assign tw_idx  = tw_k << tw_sh;

    logic signed [WW-1:0] a_re, a_im, b_re, b_im;
    assign a_re = r_rd_a[WW-1:0];
    assign a_im = r_rd_a[2*WW-1:WW];
    assign b_re = r_rd_b[WW-1:0];
    assign b_im = r_rd_b[2*WW-1:WW];

    // Shared multiplier operands.
    logic signed [WW-1:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            fblm_pkg::S_LMUL: begin
                mul_a = WW'(r_x);
                mul_b = WW'({1'b0, r_win});
            end
            fblm_pkg::S_FM0: begin mul_a = b_re; mul_b = r_wr; end
            fblm_pkg::S_FM1: begin mul_a = b_im; mul_b = r_wi; end
            fblm_pkg::S_FM2: begin mul_a = b_im; mul_b = r_wr; end
            fblm_pkg::S_FM3: begin mul_a = b_re; mul_b = r_wi; end
            fblm_pkg::S_PRE: begin mul_a = a_re; mul_b = a_re; end
            fblm_pkg::S_PIM: begin mul_a = a_im; mul_b = a_im; end
            fblm_pkg::S_LVL: begin
                mul_a = WW'({1'b0, r_root});
                mul_b = WW'({1'b0, r_level_gain});
            end
            default: ;
        endcase
    end

    // Rounded twiddle products.
    logic signed [48:0] tw_diff, tw_sum, tr_full, ti_full;
    assign tw_diff = r_acc - 49'(r_prod);
    assign tw_sum  = r_acc + 49'(r_prod);
    assign tr_full = (tw_diff + 49'sd16384) >>> 15;
    assign ti_full = (tw_sum + 49'sd16384) >>> 15;

    // Butterfly outputs, halved with rounding.
    logic signed [27:0] s_re, s_im, d_re, d_im;
    logic signed [27:0] hs_re, hs_im, hd_re, hd_im;
    assign s_re  = 28'(a_re) + 28'(r_tr);
    assign s_im  = 28'(a_im) + 28'(r_ti);
    assign d_re  = 28'(a_re) - 28'(r_tr);
    assign d_im  = 28'(a_im) - 28'(r_ti);
    assign hs_re = (s_re + 28'sd1) >>> 1;
    assign hs_im = (s_im + 28'sd1) >>> 1;
    assign hd_re = (d_re + 28'sd1) >>> 1;
    assign hd_im = (d_im + 28'sd1) >>> 1;

    // Windowed load word.
    logic signed [47:0] ld_full;
    logic signed [WW-1:0] ld_word;
    assign ld_full = (r_prod + 48'sd128) >>> 8;
    assign ld_word = fblm_pkg::sat24(ld_full);

    // Magnitude squared.
    logic [fblm_pkg::SQ_IN_W-1:0] m2;
    assign m2 = r_acc[fblm_pkg::SQ_IN_W-1:0] + r_prod[fblm_pkg::SQ_IN_W-1:0];

    // Level and bar update.
    logic [32:0] lvl_sum;
    logic [20:0] lvl_raw;
    logic [16:0] lvl;
    logic [15:0] bar_cur;
    logic [17:0] bar_dec;
    logic [15:0] bar_new;
    assign lvl_sum = r_prod[32:0] + 33'd2048;
    assign lvl_raw = lvl_sum[32:12];
    assign lvl     = (lvl_raw > 21'(fblm_pkg::LEVEL_ONE)) ? fblm_pkg::LEVEL_ONE : lvl_raw[16:0];
    assign bar_cur = r_bar[r_band];
    assign bar_dec = {2'b00, bar_cur} - {2'b00, r_fall_step};
    always_comb begin
        if (lvl > {1'b0, bar_cur})
            bar_new = lvl[15:0];
        else if (bar_dec[17] || (bar_dec[16:0] < lvl))
            bar_new = lvl[15:0];
        else
            bar_new = bar_dec[15:0];
    end

    assign in_take  = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    logic last_bfly;
    logic last_band;
    assign last_bfly = (r_bfly == '1) &&
                       (r_stage == fblm_pkg::STAGE_W'(fblm_pkg::LOG2_POINTS - 1));
    assign last_band = (r_band == fblm_pkg::BAND_W'(fblm_pkg::NUM_BANDS - 1));

    // ------------------------------------------------------------------
    // Next state and control.
    always_comb begin
        n_state         = r_state;
        o_s_tready      = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = addr_a;
        mem_wd          = '0;
        sq_req.start    = 1'b0;
        sq_req.radicand = r_peak;
        case (r_state)
            fblm_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid)
                    n_state = fblm_pkg::S_LMUL;
            end
            fblm_pkg::S_LMUL: n_state = fblm_pkg::S_LWR;
            fblm_pkg::S_LWR: begin
                mem_we  = (r_fc < fblm_pkg::FC_W'(fblm_pkg::FFT_POINTS));
                mem_wa  = fblm_pkg::bitrev(r_fc[fblm_pkg::ADDR_W-1:0]);
                mem_wd  = {{WW{1'b0}}, ld_word};
                n_state = r_last ? fblm_pkg::S_PAD : fblm_pkg::S_IDLE;
            end
            fblm_pkg::S_PAD: begin
                mem_wa = fblm_pkg::bitrev(r_fc[fblm_pkg::ADDR_W-1:0]);
                if (r_fc < fblm_pkg::FC_W'(fblm_pkg::FFT_POINTS))
                    mem_we = 1'b1;
                else
                    n_state = fblm_pkg::S_FRD;
            end
            fblm_pkg::S_FRD: n_state = fblm_pkg::S_FM0;
            fblm_pkg::S_FM0: n_state = fblm_pkg::S_FM1;
            fblm_pkg::S_FM1: n_state = fblm_pkg::S_FM2;
            fblm_pkg::S_FM2: n_state = fblm_pkg::S_FM3;
            fblm_pkg::S_FM3: n_state = fblm_pkg::S_FM4;
            fblm_pkg::S_FM4: n_state = fblm_pkg::S_FWA;
            fblm_pkg::S_FWA: begin
                mem_we  = 1'b1;
                mem_wa  = addr_a;
                mem_wd  = {fblm_pkg::sat24(48'(hs_im)), fblm_pkg::sat24(48'(hs_re))};
                n_state = fblm_pkg::S_FWB;
            end
            fblm_pkg::S_FWB: begin
                mem_we  = 1'b1;
                mem_wa  = addr_b;
                mem_wd  = r_new_b;
                n_state = last_bfly ? fblm_pkg::S_BINIT : fblm_pkg::S_FRD;
            end
            fblm_pkg::S_BINIT: n_state = fblm_pkg::S_PCHK;
            fblm_pkg::S_PCHK: begin
                if (r_bin < fblm_pkg::BAND_HI[r_band])
                    n_state = fblm_pkg::S_PRD;
                else
                    n_state = fblm_pkg::S_SQS1;
            end
            fblm_pkg::S_PRD:  n_state = fblm_pkg::S_PRE;
            fblm_pkg::S_PRE:  n_state = fblm_pkg::S_PIM;
            fblm_pkg::S_PIM:  n_state = fblm_pkg::S_PCMP;
            fblm_pkg::S_PCMP: n_state = fblm_pkg::S_PCHK;
            fblm_pkg::S_SQS1: begin
                sq_req.start = 1'b1;
                n_state      = fblm_pkg::S_SQW1;
            end
            fblm_pkg::S_SQW1: if (sq_rsp.done) n_state = fblm_pkg::S_SQS2;
            fblm_pkg::S_SQS2: begin
                sq_req.start    = 1'b1;
                sq_req.radicand = fblm_pkg::SQ_IN_W'({r_mag, 8'h00});
                n_state         = fblm_pkg::S_SQW2;
            end
            fblm_pkg::S_SQW2: if (sq_rsp.done) n_state = fblm_pkg::S_LVL;
            fblm_pkg::S_LVL:  n_state = fblm_pkg::S_EMIT;
            fblm_pkg::S_EMIT: begin
                if (out_free)
                    n_state = last_band ? fblm_pkg::S_IDLE : fblm_pkg::S_BINIT;
            end
            default: n_state = fblm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fblm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo_mix <= fblm_pkg::STEREO_MIX_RST;
            r_fall_step  <= fblm_pkg::FALL_STEP_RST;
            r_level_gain <= fblm_pkg::LEVEL_GAIN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                fblm_pkg::CFG_STEREO_MIX: r_stereo_mix <= i_cfg_data[0];
                fblm_pkg::CFG_FALL_STEP:  r_fall_step  <= i_cfg_data;
                fblm_pkg::CFG_LEVEL_GAIN: r_level_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample RAM and window ROM.
    assign rd_addr_a = (r_state inside {fblm_pkg::S_PRD, fblm_pkg::S_PRE,
                                        fblm_pkg::S_PIM}) ? r_bin : addr_a;
    assign rd_addr_b = addr_b;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_wa] <= mem_wd;
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_win <= fblm_pkg::WIN_TAB[r_fc[fblm_pkg::ADDR_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc    <= '0;
            r_stage <= '0;
            r_bfly  <= '0;
            r_band  <= '0;
        end else begin
            case (r_state)
                fblm_pkg::S_LWR: begin
                    if (r_fc < fblm_pkg::FC_W'(fblm_pkg::FFT_POINTS))
                        r_fc <= r_fc + 1'b1;
                end
                fblm_pkg::S_PAD: begin
                    if (r_fc < fblm_pkg::FC_W'(fblm_pkg::FFT_POINTS)) begin
                        r_fc <= r_fc + 1'b1;
                    end else begin
                        r_fc    <= '0;
                        r_stage <= '0;
                        r_bfly  <= '0;
                        r_band  <= '0;
                    end
                end
                fblm_pkg::S_FWB: begin
                    r_bfly <= r_bfly + 1'b1;
                    if (r_bfly == '1)
                        r_stage <= r_stage + 1'b1;
                end
                fblm_pkg::S_EMIT: begin
                    if (out_free)
                        r_band <= last_band ? '0 : r_band + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            fblm_pkg::S_IDLE: begin
                if (in_take) begin
                    r_last <= i_s_tlast;
                    if (r_stereo_mix)
                        r_x <= 17'(signed'(i_s_tdata[15:0])) +
                               17'(signed'(i_s_tdata[31:16]));
                    else
                        r_x <= {i_s_tdata[15:0], 1'b0};
                end
            end
            fblm_pkg::S_LMUL: r_prod <= mul_a * mul_b;
            fblm_pkg::S_FRD: begin
                r_wr <= WW'(fblm_pkg::COS_TAB[tw_idx]);
                r_wi <= -WW'(fblm_pkg::SIN_TAB[tw_idx]);
            end
            fblm_pkg::S_FM0: r_prod <= mul_a * mul_b;
            fblm_pkg::S_FM1: begin
                r_acc  <= 49'(r_prod);
                r_prod <= mul_a * mul_b;
            end
            fblm_pkg::S_FM2: begin
                r_tr   <= tr_full[26:0];
                r_prod <= mul_a * mul_b;
            end
            fblm_pkg::S_FM3: begin
                r_acc  <= 49'(r_prod);
                r_prod <= mul_a * mul_b;
            end
            fblm_pkg::S_FM4: r_ti <= ti_full[26:0];
            fblm_pkg::S_FWA: begin
                r_new_b <= {fblm_pkg::sat24(48'(hd_im)), fblm_pkg::sat24(48'(hd_re))};
            end
            fblm_pkg::S_BINIT: begin
                r_bin  <= fblm_pkg::BAND_LO[r_band];
                r_peak <= '0;
            end
            fblm_pkg::S_PRE: r_prod <= mul_a * mul_b;
            fblm_pkg::S_PIM: begin
                r_acc  <= 49'(r_prod);
                r_prod <= mul_a * mul_b;
            end
            fblm_pkg::S_PCMP: begin
                if (m2 > r_peak)
                    r_peak <= m2;
                r_bin <= r_bin + 1'b1;
            end
            fblm_pkg::S_SQW1: if (sq_rsp.done) r_mag <= sq_rsp.root;
            fblm_pkg::S_SQW2: if (sq_rsp.done) r_root <= sq_rsp.root[15:0];
            fblm_pkg::S_LVL:  r_prod <= mul_a * mul_b;
            default: ;
        endcase
    end

    // Bar store, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fblm_pkg::NUM_BANDS; i++)
                r_bar[i] <= '0;
        end else if (r_state == fblm_pkg::S_EMIT && out_free) begin
            r_bar[r_band] <= bar_new;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == fblm_pkg::S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fblm_pkg::S_EMIT && out_free) begin
            r_out_band  <= r_band;
            r_out_level <= bar_new;
            r_out_last  <= last_band;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = fblm_pkg::OUT_DATA_W'({r_out_level, r_out_band});
    assign o_m_tlast  = r_out_last;

    fblm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // ------------------------------------------------------------------
    // Assertions.
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= fblm_pkg::FC_W'(fblm_pkg::FFT_POINTS))
        else $error("frame count past the FFT size");

    a_last_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
        (r_out_band == fblm_pkg::BAND_W'(fblm_pkg::NUM_BANDS - 1)))
        else $error("tlast on a band other than the last");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, r_out_level} <= fblm_pkg::LEVEL_ONE))
        else $error("bar level above full scale");

    a_wb_after_wa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fblm_pkg::S_FWB) |-> ($past(r_state) == fblm_pkg::S_FWA))
        else $error("second butterfly write without the first");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_rsp.done |-> (r_state == fblm_pkg::S_SQW1 || r_state == fblm_pkg::S_SQW2))
        else $error("square root finished while nobody waits");

endmodule
